// ===== rtl/core/selective_repeat_arq_window_unit_defines.svh =====
// Assertion macros for the ARQ window unit.
`ifndef SELECTIVE_REPEAT_ARQ_WINDOW_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_WINDOW_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SRAW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sraw: property violated");
`define SRAW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sraw: next-cycle property violated");
`else
`define SRAW_ASSERT(lbl, prop)
`define SRAW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/sraw_pkg.sv =====
package sraw_pkg;

  localparam int WIN_MAX = 16;
  localparam int SLOT_W  = $clog2(WIN_MAX);
  localparam int WIN_W   = $clog2(WIN_MAX + 1);
  localparam int SEQ_W   = 16;
  localparam int TMR_W   = 8;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_ACK   = 2'd2;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_FRAMES  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    KIND_SEND     = 3'd0,
    KIND_TIMEOUT  = 3'd1,
    KIND_IN_ORDER = 3'd2,
    KIND_BUFFERED = 3'd3,
    KIND_DISCARD  = 3'd4,
    KIND_DELIVER  = 3'd5,
    KIND_ACK      = 3'd6,
    KIND_STATUS   = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD,
    OP_TICK1,
    OP_REWIND,
    OP_TICK2,
    OP_FCHK,
    OP_FSCAN,
    OP_FPEND,
    OP_FDLV,
    OP_FACK,
    OP_ACHK,
    OP_ASLIDE,
    OP_STAT
  } op_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       mod_done;
    logic       at_end;
    logic       hit;
    logic       ack_ok;
    logic       scan_go;
    logic       dlv_done;
    logic       slide_go;
  } stat_t;

endpackage

// ===== rtl/core/sraw_dp.sv =====
module sraw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sraw_pkg::op_e                 op_i,
  input  logic [1:0]                    mode_i,
  input  logic [sraw_pkg::SEQ_W-1:0]    seq_in_i,
  input  logic [sraw_pkg::WIN_W-1:0]    win_i,
  input  logic [sraw_pkg::SEQ_W-1:0]    fc_i,
  input  logic [sraw_pkg::TMR_W-1:0]    tmo_i,
  output sraw_pkg::stat_t               stat_o,
  output logic                          valid_o,
  output logic [2:0]                    kind_o,
  output logic [sraw_pkg::SEQ_W-1:0]    seq_out_o,
  output logic [sraw_pkg::SEQ_W-1:0]    send_base_out_o,
  output logic [sraw_pkg::SEQ_W-1:0]    recv_base_out_o,
  output logic                          all_done_o,
  output logic                          last_o
);
  import sraw_pkg::*;

  logic [SEQ_W-1:0]  sb_q, rb_q, end_q, cur_q, seq_q, opnd_q;
  logic [1:0]        mode_q;
  logic [SLOT_W-1:0] slot_q, bslot_q, rem_q;
  logic [3:0]        cnt_q;
  logic              pend_q;
  kind_e             pend_kind_q;
  logic [WIN_MAX-1:0] ack_q, sent_q, rcv_q;
  logic [TMR_W-1:0]  tmr_q [WIN_MAX];

  logic              ovalid_q, olast_q, odone_q;
  kind_e             okind_q;
  logic [SEQ_W-1:0]  oseq_q, osb_q, orb_q;

  logic [SEQ_W:0]    sb_lim, hlim;
  logic [SEQ_W-1:0]  hbase, hoff, ld_base;
  logic [WIN_W-1:0]  hsum, hsum_w, rsh, rsh_w, slot_nx;
  logic [SLOT_W-1:0] hslot, slot_inc, rnew;
  logic [TMR_W-1:0]  tdec;
  logic              hit;
  logic              scan_go;
  logic              emit;
  kind_e             ekind;
  logic [SEQ_W-1:0]  eseq;

  assign sb_lim = {1'b0, sb_q} + {{(SEQ_W+1-WIN_W){1'b0}}, win_i};
  assign hbase  = (mode_q == MODE_FRAME) ? rb_q : sb_q;
  assign hlim   = {1'b0, hbase} + {{(SEQ_W+1-WIN_W){1'b0}}, win_i};
  assign hit    = (seq_q >= hbase) && ({1'b0, seq_q} < hlim) && (seq_q < fc_i);
  assign hoff   = seq_q - hbase;
  // offset is below the window when hit, so a single wrap suffices
  assign hsum   = {1'b0, bslot_q} + hoff[WIN_W-1:0];
  assign hsum_w = hsum - win_i;
  assign hslot  = (hsum >= win_i) ? hsum_w[SLOT_W-1:0] : hsum[SLOT_W-1:0];

  // stop the in-order run at the end of the receive window
  assign scan_go = (cur_q < fc_i) && ({1'b0, cur_q} < hlim) && rcv_q[slot_q];

  assign slot_nx  = {1'b0, slot_q} + WIN_W'(1);
  assign slot_inc = (slot_nx == win_i) ? '0 : slot_nx[SLOT_W-1:0];

  assign rsh   = {rem_q, opnd_q[SEQ_W-1]};
  assign rsh_w = rsh - win_i;
  assign rnew  = (rsh >= win_i) ? rsh_w[SLOT_W-1:0] : rsh[SLOT_W-1:0];

  assign ld_base = (mode_i == MODE_FRAME) ? rb_q : sb_q;
  assign tdec    = (tmr_q[slot_q] == '0) ? '0 : tmr_q[slot_q] - TMR_W'(1);

  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.mod_done = (cnt_q == 4'd15);
    stat_o.at_end   = ({1'b0, cur_q} >= sb_lim) || (cur_q >= fc_i);
    stat_o.hit      = hit;
    stat_o.ack_ok   = hit && !ack_q[hslot];
    stat_o.scan_go  = scan_go;
    stat_o.dlv_done = (cur_q == end_q);
    stat_o.slide_go = (sb_q < fc_i) && ack_q[slot_q];
  end

  always_comb begin
    emit  = 1'b0;
    ekind = KIND_STATUS;
    eseq  = '0;
    case (op_i)
      OP_TICK1: begin
        if (sent_q[slot_q] && !ack_q[slot_q] && tdec == '0) begin
          emit  = 1'b1;
          ekind = KIND_TIMEOUT;
          eseq  = cur_q;
        end
      end
      OP_TICK2: begin
        if (!ack_q[slot_q] && !sent_q[slot_q]) begin
          emit  = 1'b1;
          ekind = KIND_SEND;
          eseq  = cur_q;
        end
      end
      OP_FCHK: begin
        if (!hit) begin
          emit  = 1'b1;
          ekind = KIND_DISCARD;
          eseq  = seq_q;
        end
      end
      OP_FPEND: begin
        emit  = pend_q;
        ekind = pend_kind_q;
        eseq  = seq_q;
      end
      OP_FDLV: begin
        emit  = 1'b1;
        ekind = KIND_DELIVER;
        eseq  = cur_q;
      end
      OP_FACK: begin
        emit  = 1'b1;
        ekind = KIND_ACK;
        eseq  = seq_q;
      end
      OP_STAT: begin
        emit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q   <= '0;
      rb_q   <= '0;
      ack_q  <= '0;
      sent_q <= '0;
      rcv_q  <= '0;
      for (int i = 0; i < WIN_MAX; i++) tmr_q[i] <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      case (op_i)
        OP_LOAD: begin
          mode_q <= mode_i;
          seq_q  <= seq_in_i;
          opnd_q <= ld_base;
          rem_q  <= '0;
          cnt_q  <= '0;
          end_q  <= rb_q;
          pend_q <= 1'b0;
        end
        OP_MOD: begin
          // serial remainder of the base, one bit a cycle
          rem_q  <= rnew;
          opnd_q <= {opnd_q[SEQ_W-2:0], 1'b0};
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            cur_q   <= hbase;
            slot_q  <= rnew;
            bslot_q <= rnew;
          end
        end
        OP_TICK1: begin
          if (sent_q[slot_q] && !ack_q[slot_q]) begin
            tmr_q[slot_q] <= tdec;
            if (tdec == '0) sent_q[slot_q] <= 1'b0;
          end
          cur_q  <= cur_q + SEQ_W'(1);
          slot_q <= slot_inc;
        end
        OP_REWIND: begin
          cur_q  <= sb_q;
          slot_q <= bslot_q;
        end
        OP_TICK2: begin
          if (!ack_q[slot_q] && !sent_q[slot_q]) begin
            sent_q[slot_q] <= 1'b1;
            tmr_q[slot_q]  <= tmo_i;
          end
          cur_q  <= cur_q + SEQ_W'(1);
          slot_q <= slot_inc;
        end
        OP_FCHK: begin
          if (hit && !rcv_q[hslot]) begin
            rcv_q[hslot] <= 1'b1;
            pend_q       <= 1'b1;
            pend_kind_q  <= (seq_q == rb_q) ? KIND_IN_ORDER : KIND_BUFFERED;
          end
        end
        OP_FSCAN: begin
          if (scan_go) begin
            cur_q  <= cur_q + SEQ_W'(1);
            slot_q <= slot_inc;
          end else begin
            // hold the new base, rewind for delivery
            end_q  <= cur_q;
            cur_q  <= rb_q;
            slot_q <= bslot_q;
          end
        end
        OP_FDLV: begin
          rcv_q[slot_q] <= 1'b0;
          cur_q  <= cur_q + SEQ_W'(1);
          slot_q <= slot_inc;
        end
        OP_FACK: begin
          rb_q <= end_q;
        end
        OP_ACHK: begin
          if (hit && !ack_q[hslot]) begin
            ack_q[hslot]  <= 1'b1;
            sent_q[hslot] <= 1'b0;
            tmr_q[hslot]  <= '0;
          end
        end
        OP_ASLIDE: begin
          ack_q[slot_q]  <= 1'b0;
          sent_q[slot_q] <= 1'b0;
          tmr_q[slot_q]  <= '0;
          sb_q   <= sb_q + SEQ_W'(1);
          slot_q <= slot_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      okind_q <= ekind;
      oseq_q  <= eseq;
      osb_q   <= sb_q;
      orb_q   <= end_q;
      odone_q <= (sb_q >= fc_i);
      olast_q <= (op_i == OP_STAT);
    end
  end

  assign valid_o         = ovalid_q;
  assign kind_o          = okind_q;
  assign seq_out_o       = oseq_q;
  assign send_base_out_o = osb_q;
  assign recv_base_out_o = orb_q;
  assign all_done_o      = odone_q;
  assign last_o          = olast_q;

endmodule

// ===== rtl/core/sraw_ctrl.sv =====
module sraw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      mode_i,
  input  sraw_pkg::stat_t stat_i,
  output sraw_pkg::op_e   op_o,
  output logic            busy_o
);
  import sraw_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_MOD    = 12'b0000_0000_0010,
    ST_TICK1  = 12'b0000_0000_0100,
    ST_TICK2  = 12'b0000_0000_1000,
    ST_FCHK   = 12'b0000_0001_0000,
    ST_FSCAN  = 12'b0000_0010_0000,
    ST_FPEND  = 12'b0000_0100_0000,
    ST_FDLV   = 12'b0000_1000_0000,
    ST_FACK   = 12'b0001_0000_0000,
    ST_ACHK   = 12'b0010_0000_0000,
    ST_ASLIDE = 12'b0100_0000_0000,
    ST_STAT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_o    = OP_LOAD;
          state_d = (mode_i == MODE_TICK || mode_i == MODE_FRAME || mode_i == MODE_ACK)
                    ? ST_MOD : ST_STAT;
        end
      end
      ST_MOD: begin
        op_o = OP_MOD;
        if (stat_i.mod_done) begin
          case (stat_i.mode)
            MODE_TICK:  state_d = ST_TICK1;
            MODE_FRAME: state_d = ST_FCHK;
            default:    state_d = ST_ACHK;
          endcase
        end
      end
      ST_TICK1: begin
        if (stat_i.at_end) begin
          op_o    = OP_REWIND;
          state_d = ST_TICK2;
        end else begin
          op_o = OP_TICK1;
        end
      end
      ST_TICK2: begin
        if (stat_i.at_end) state_d = ST_STAT;
        else op_o = OP_TICK2;
      end
      ST_FCHK: begin
        op_o    = OP_FCHK;
        state_d = stat_i.hit ? ST_FSCAN : ST_STAT;
      end
      ST_FSCAN: begin
        op_o = OP_FSCAN;
        if (!stat_i.scan_go) state_d = ST_FPEND;
      end
      ST_FPEND: begin
        op_o    = OP_FPEND;
        state_d = ST_FDLV;
      end
      ST_FDLV: begin
        if (stat_i.dlv_done) state_d = ST_FACK;
        else op_o = OP_FDLV;
      end
      ST_FACK: begin
        op_o    = OP_FACK;
        state_d = ST_STAT;
      end
      ST_ACHK: begin
        op_o    = OP_ACHK;
        state_d = stat_i.ack_ok ? ST_ASLIDE : ST_STAT;
      end
      ST_ASLIDE: begin
        if (stat_i.slide_go) op_o = OP_ASLIDE;
        else state_d = ST_STAT;
      end
      ST_STAT: begin
        op_o    = OP_STAT;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/selective_repeat_arq_window_unit.sv =====
// Channel   Direction  Handshake                        Payload
// command   in         start high while busy low        mode_i, seq_in_i
// result    out        valid_o strobe, one cycle each   kind_o, seq_out_o, send_base_out_o,
//                                                       recv_base_out_o, all_done_o, last_o
// config    in         APB write, pready always high    pwdata at paddr 0/4/8
//
// Each item is loaded in its accept cycle, a serial remainder finds the base slot, then the
// window is walked one slot a cycle: a tick runs a timeout pass to the send limit, a rewind
// and a send pass; a frame a check, an in-order scan, delivery and an ack, else a discard;
// an ACK a check and slides unless ignored; an unknown mode goes to status. Results leave
// at most one a cycle from a registered output; the status result comes in the cycle busy
// drops. Reset clears all windows and both bases. The receiver cannot stall results.
`include "selective_repeat_arq_window_unit_defines.svh"

module selective_repeat_arq_window_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode_i,
  input  logic [sraw_pkg::SEQ_W-1:0] seq_in_i,
  output logic                       valid_o,
  output logic [2:0]                 kind_o,
  output logic [sraw_pkg::SEQ_W-1:0] seq_out_o,
  output logic [sraw_pkg::SEQ_W-1:0] send_base_out_o,
  output logic [sraw_pkg::SEQ_W-1:0] recv_base_out_o,
  output logic                       all_done_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sraw_pkg::*;

  logic [4:0]       win_reg_q;
  logic [SEQ_W-1:0] fc_q;
  logic [TMR_W-1:0] tmo_q;
  logic [WIN_W-1:0] win_eff;
  logic             wr_en;
  op_e              op;
  stat_t            stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_reg_q <= 5'd4;
      fc_q      <= 16'd16;
      tmo_q     <= 8'd3;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WINDOW:  win_reg_q <= pwdata[4:0];
        REG_FRAMES:  fc_q      <= pwdata[SEQ_W-1:0];
        REG_TIMEOUT: tmo_q     <= pwdata[TMR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW:  prdata = {27'd0, win_reg_q};
      REG_FRAMES:  prdata = {16'd0, fc_q};
      REG_TIMEOUT: prdata = {24'd0, tmo_q};
      default:     prdata = '0;
    endcase
  end

  // clamp the window to 1..WIN_MAX
  always_comb begin
    if (win_reg_q == '0) win_eff = WIN_W'(1);
    else if ({{(32-5){1'b0}}, win_reg_q} > WIN_MAX) win_eff = WIN_W'(WIN_MAX);
    else win_eff = WIN_W'(win_reg_q);
  end

  sraw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (mode_i),
    .stat_i (stat),
    .op_o   (op),
    .busy_o (busy)
  );

  sraw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .mode_i         (mode_i),
    .seq_in_i       (seq_in_i),
    .win_i          (win_eff),
    .fc_i           (fc_q),
    .tmo_i          (tmo_q),
    .stat_o         (stat),
    .valid_o        (valid_o),
    .kind_o         (kind_o),
    .seq_out_o      (seq_out_o),
    .send_base_out_o(send_base_out_o),
    .recv_base_out_o(recv_base_out_o),
    .all_done_o     (all_done_o),
    .last_o         (last_o)
  );

  `SRAW_ASSERT(a_last_is_status, (valid_o && last_o) |-> (kind_o == KIND_STATUS))
  `SRAW_ASSERT(a_last_frees_unit, (valid_o && last_o) |-> !busy)
  `SRAW_ASSERT_NXT(a_start_goes_busy, start && !busy, busy)

endmodule
